>>> rtl/core/bfspa_pkg.sv
package bfspa_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SIZE_BITS  = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int BYTES_W    = 40;
    localparam int STAMP_W    = 32;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_PEAK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_NO_SLOT = 2'd1,
        ERR_NOT_LIVE = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] request_bytes;
        logic [5:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic         ok;
        logic [1:0]   error_code;
        logic [5:0]   granted_slot;
        logic [39:0]  total_bytes;
        logic [39:0]  peak_bytes;
        logic [6:0]   live_count;
        logic [39:0]  retained_bytes;
        logic [6:0]   kept_count;
    } out_item_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] cap;
        logic [SIZE_BITS-1:0] size;
        logic [STAMP_W-1:0]   stamp;
    } slot_rec_t;

endpackage

>>> rtl/core/best_fit_slot_pool_allocator_unit.sv
// channel | dir | handshake   | payload
// in      | in  | valid/stall | bfspa_pkg::in_item_t
// out     | out | valid/stall | bfspa_pkg::out_item_t
// an allocate runs ST_SCAN, ST_LAST, ST_COMMIT: one record read per slot in the scan
// a free runs ST_FREE_RD, ST_FREE_WR; every mode ends in ST_OUT, which loads the beat
// one item at a time; in_stall is high from acceptance until the result beat is taken
// reset clears slot flags and totals at once; the scan reads unused records but drops them
// out_stall holds the result beat stable in the output register
module best_fit_slot_pool_allocator_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bfspa_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bfspa_pkg::out_item_t  out_data
);

    localparam int SW = bfspa_pkg::SLOT_W;
    localparam int ZW = bfspa_pkg::SIZE_BITS;
    localparam int TW = bfspa_pkg::STAMP_W;
    localparam int BW = bfspa_pkg::BYTES_W;
    localparam int CW = bfspa_pkg::CNT_W;
    localparam int N  = bfspa_pkg::SLOT_COUNT;

    // slot record memory
    bfspa_pkg::slot_rec_t mem [N];
    logic [SW-1:0]          rd_addr;
    bfspa_pkg::slot_rec_t rd_data_reg;
    logic                   wr_en;
    logic [SW-1:0]          wr_addr;
    bfspa_pkg::slot_rec_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control and totals
    bfspa_pkg::state_t state_reg, state_next;
    logic [N-1:0]    live_reg, freed_reg;
    logic [SW:0]     idx_reg;
    logic [SW-1:0]   prev_reg;
    bfspa_pkg::in_item_t item_reg;
    logic [ZW-1:0]   req;
    logic            fit_found_reg, big_found_reg;
    logic [SW-1:0]   fit_slot_reg, big_slot_reg;
    logic [ZW-1:0]   fit_cap_reg, big_cap_reg;
    logic [TW-1:0]   fit_age_reg, big_age_reg;
    logic [TW-1:0]   stamp_ctr_reg;
    logic [CW-1:0]   next_unused_reg;
    logic [BW-1:0]   live_bytes_reg, peak_reg, kept_bytes_reg;
    logic [6:0]      live_slots_reg, kept_slots_reg;
    logic            out_valid_reg;
    bfspa_pkg::out_item_t out_reg;

    assign req       = item_reg.request_bytes[ZW-1:0];
    assign in_stall  = (state_reg != bfspa_pkg::ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfspa_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    priority if (in_data.mode == bfspa_pkg::MODE_ALLOC)
                        state_next = bfspa_pkg::ST_SCAN;
                    else if (in_data.mode == bfspa_pkg::MODE_FREE)
                        state_next = bfspa_pkg::ST_FREE_RD;
                    else
                        state_next = bfspa_pkg::ST_OUT;
                end
            end
            bfspa_pkg::ST_SCAN:
                if (idx_reg == (SW+1)'(N - 1)) state_next = bfspa_pkg::ST_LAST;
            bfspa_pkg::ST_LAST:    state_next = bfspa_pkg::ST_COMMIT;
            bfspa_pkg::ST_COMMIT:  state_next = bfspa_pkg::ST_OUT;
            bfspa_pkg::ST_FREE_RD: state_next = bfspa_pkg::ST_FREE_WR;
            bfspa_pkg::ST_FREE_WR: state_next = bfspa_pkg::ST_OUT;
            bfspa_pkg::ST_OUT:     state_next = bfspa_pkg::ST_IDLE;
            default:               state_next = bfspa_pkg::ST_IDLE;
        endcase
    end

    // candidate from the record read last cycle
    logic [TW-1:0] cand_age;
    logic          cand_freed, fit_take, big_take, scan_cmp;
    assign cand_age   = stamp_ctr_reg - rd_data_reg.stamp;
    assign cand_freed = freed_reg[prev_reg];
    assign scan_cmp   = (state_reg == bfspa_pkg::ST_SCAN && idx_reg != '0)
                        || state_reg == bfspa_pkg::ST_LAST;
    assign fit_take = scan_cmp && cand_freed && rd_data_reg.cap >= req &&
        (!fit_found_reg || rd_data_reg.cap < fit_cap_reg ||
         (rd_data_reg.cap == fit_cap_reg && cand_age < fit_age_reg));
    assign big_take = scan_cmp && cand_freed &&
        (!big_found_reg || rd_data_reg.cap > big_cap_reg ||
         (rd_data_reg.cap == big_cap_reg && cand_age < big_age_reg));

    // commit decision
    logic          use_fit, use_new, use_big, grant;
    logic [SW-1:0] gslot;
    logic [ZW-1:0] old_cap, new_cap;
    always_comb
    begin
        use_fit = fit_found_reg;
        use_new = !fit_found_reg && (next_unused_reg < CW'(N));
        use_big = !fit_found_reg && !use_new && big_found_reg;
        grant   = use_fit || use_new || use_big;
        gslot   = use_fit ? fit_slot_reg : use_new ? next_unused_reg[SW-1:0] : big_slot_reg;
        old_cap = use_fit ? fit_cap_reg : big_cap_reg;
        new_cap = use_new ? req : (use_big && req > big_cap_reg) ? req : old_cap;
    end

    // memory port drive
    logic free_ok;
    assign free_ok = live_reg[item_reg.slot_index[SW-1:0]];
    always_comb
    begin
        rd_addr = idx_reg[SW-1:0];
        if (state_reg == bfspa_pkg::ST_FREE_RD)
            rd_addr = item_reg.slot_index[SW-1:0];
        wr_en   = 1'b0;
        wr_addr = gslot;
        // a live slot carries no free stamp
        wr_data = '{cap: new_cap, size: req, stamp: '0};
        if (state_reg == bfspa_pkg::ST_COMMIT)
        begin
            wr_en = grant;
        end
        else if (state_reg == bfspa_pkg::ST_FREE_WR)
        begin
            wr_en   = free_ok;
            wr_addr = item_reg.slot_index[SW-1:0];
            wr_data = '{cap: rd_data_reg.cap, size: '0, stamp: stamp_ctr_reg};
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bfspa_pkg::ST_IDLE;
            live_reg        <= '0;
            freed_reg       <= '0;
            idx_reg         <= '0;
            prev_reg        <= '0;
            item_reg        <= '0;
            fit_found_reg   <= 1'b0;
            big_found_reg   <= 1'b0;
            fit_slot_reg    <= '0;
            big_slot_reg    <= '0;
            fit_cap_reg     <= '0;
            big_cap_reg     <= '0;
            fit_age_reg     <= '0;
            big_age_reg     <= '0;
            stamp_ctr_reg   <= '0;
            next_unused_reg <= '0;
            live_bytes_reg  <= '0;
            peak_reg        <= '0;
            kept_bytes_reg  <= '0;
            live_slots_reg  <= '0;
            kept_slots_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            unique case (state_reg)
                bfspa_pkg::ST_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg      <= in_data;
                        idx_reg       <= '0;
                        fit_found_reg <= 1'b0;
                        big_found_reg <= 1'b0;
                        out_reg       <= '0;
                    end
                end
                bfspa_pkg::ST_SCAN, bfspa_pkg::ST_LAST:
                begin
                    prev_reg <= idx_reg[SW-1:0];
                    idx_reg  <= idx_reg + 1'b1;
                    if (fit_take)
                    begin
                        fit_found_reg <= 1'b1;
                        fit_slot_reg  <= prev_reg;
                        fit_cap_reg   <= rd_data_reg.cap;
                        fit_age_reg   <= cand_age;
                    end
                    if (big_take)
                    begin
                        big_found_reg <= 1'b1;
                        big_slot_reg  <= prev_reg;
                        big_cap_reg   <= rd_data_reg.cap;
                        big_age_reg   <= cand_age;
                    end
                end
                bfspa_pkg::ST_COMMIT:
                begin
                    if (grant)
                    begin
                        if (!use_new)
                        begin
                            kept_bytes_reg <= kept_bytes_reg - BW'(old_cap);
                            kept_slots_reg <= kept_slots_reg - 1'b1;
                            freed_reg[gslot] <= 1'b0;
                        end
                        else
                        begin
                            next_unused_reg <= next_unused_reg + 1'b1;
                        end
                        live_reg[gslot] <= 1'b1;
                        live_bytes_reg  <= live_bytes_reg + BW'(req);
                        if (live_bytes_reg + BW'(req) > peak_reg)
                            peak_reg <= live_bytes_reg + BW'(req);
                        live_slots_reg  <= live_slots_reg + 1'b1;
                        out_reg.ok           <= 1'b1;
                        out_reg.granted_slot <= gslot;
                    end
                    else
                    begin
                        out_reg.error_code <= bfspa_pkg::ERR_NO_SLOT;
                    end
                end
                bfspa_pkg::ST_FREE_RD:
                begin
                end
                bfspa_pkg::ST_FREE_WR:
                begin
                    if (free_ok)
                    begin
                        live_reg[item_reg.slot_index]  <= 1'b0;
                        freed_reg[item_reg.slot_index] <= 1'b1;
                        stamp_ctr_reg  <= stamp_ctr_reg + 1'b1;
                        live_bytes_reg <= live_bytes_reg - BW'(rd_data_reg.size);
                        kept_bytes_reg <= kept_bytes_reg + BW'(rd_data_reg.cap);
                        kept_slots_reg <= kept_slots_reg + 1'b1;
                        live_slots_reg <= live_slots_reg - 1'b1;
                        out_reg.ok     <= 1'b1;
                    end
                    else
                    begin
                        out_reg.error_code <= bfspa_pkg::ERR_NOT_LIVE;
                    end
                end
                bfspa_pkg::ST_OUT:
                begin
                    if (item_reg.mode == bfspa_pkg::MODE_PEAK)
                    begin
                        peak_reg   <= live_bytes_reg;
                        out_reg.ok <= 1'b1;
                        out_reg.peak_bytes <= live_bytes_reg;
                    end
                    else
                    begin
                        out_reg.peak_bytes <= peak_reg;
                    end
                    out_reg.total_bytes    <= live_bytes_reg;
                    out_reg.live_count     <= live_slots_reg;
                    out_reg.retained_bytes <= kept_bytes_reg;
                    out_reg.kept_count     <= kept_slots_reg;
                    out_valid_reg          <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // checks
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result beat is pending");
    a_live_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg & freed_reg) == '0)
        else $error("slot both live and freed");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        CW'($countones(live_reg)) == live_slots_reg[CW-1:0])
        else $error("live count disagrees with live flags");

endmodule
